FILE: sv/dsps_pkg.sv
`default_nettype none

package dsps_pkg;

    // Item kinds carried on the input channel.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Motor type codes held per channel.
    localparam logic [2:0] TYPE_WAVE    = 3'd1;
    localparam logic [2:0] TYPE_FULL    = 3'd2;
    localparam logic [2:0] TYPE_HALF    = 3'd3;
    localparam logic [2:0] TYPE_BIPOLAR = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TYPE_CH0   = 3'd0;
    localparam logic [2:0] CFG_TYPE_CH1   = 3'd1;
    localparam logic [2:0] CFG_STEPS_REV1 = 3'd2;
    localparam logic [2:0] CFG_STEPS_REV2 = 3'd3;
    localparam logic [2:0] CFG_STEPS_REV3 = 3'd4;
    localparam logic [2:0] CFG_STEPS_REV4 = 3'd5;

    // Phase markers: the "before the first entry" value, the last entries and the entries one past the end.
    localparam logic [3:0] PHASE_BEFORE    = 4'd15;
    localparam logic [3:0] PHASE_LAST_FULL = 4'd3;
    localparam logic [3:0] PHASE_LAST_HALF = 4'd7;
    localparam logic [3:0] PHASE_END_FULL  = 4'd4;
    localparam logic [3:0] PHASE_END_HALF  = 4'd8;

    // Widths of the speed divisor, steps per revolution, tick interval and step count.
    localparam int SPEED_W = 8;
    localparam int SREV_W  = 16;
    localparam int IVL_W   = 20;
    localparam int CNT_W   = 32;

    // Coil patterns, first coil in bit 3.
    localparam logic [3:0] PAT_WAVE [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] PAT_FULL [4] = '{4'h9, 4'h3, 4'h6, 4'hC};
    localparam logic [3:0] PAT_HALF [8] = '{4'h9, 4'h1, 4'h3, 4'h2,
                                            4'h6, 4'h4, 4'hC, 4'h8};
    localparam logic [3:0] PAT_BIP  [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_load1;
        logic div_load2;
        logic div_step;
        logic exec;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_div;
    } t_sts;

    // A stepper type has an interval computed on start.
    function automatic logic f_is_stepper(input logic [2:0] typ);
        return (typ >= TYPE_WAVE) && (typ <= TYPE_BIPOLAR);
    endfunction

    // Coil pattern for a phase; outside the table the coils keep their value.
    function automatic logic [3:0] f_pattern(input logic [2:0] typ,
                                             input logic [3:0] ph,
                                             input logic [3:0] cur);
        logic [3:0] res;
        res = cur;
        case (typ)
            TYPE_WAVE:    if (ph < PHASE_END_FULL) res = PAT_WAVE[ph[1:0]];
            TYPE_FULL:    if (ph < PHASE_END_FULL) res = PAT_FULL[ph[1:0]];
            TYPE_BIPOLAR: if (ph < PHASE_END_FULL) res = PAT_BIP[ph[1:0]];
            TYPE_HALF:    if (ph < PHASE_END_HALF) res = PAT_HALF[ph[2:0]];
            default:      res = cur;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dsps_datapath.sv
`default_nettype none

module dsps_datapath #(
    parameter int unsigned TICKS_NUMERATOR = 600000
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic [1:0]           i_kind,
    input  wire logic                 i_channel,
    input  wire logic [31:0]          i_step_count,
    input  wire logic [7:0]           i_speed,
    input  wire logic                 i_clockwise,
    input  wire dsps_pkg::t_cmd       i_cmd,
    output dsps_pkg::t_sts            o_sts,
    output logic [3:0]                o_coils_ch0,
    output logic                      o_enable_ch0,
    output logic [3:0]                o_coils_ch1,
    output logic                      o_enable_ch1,
    output logic [31:0]               o_remaining_ch0,
    output logic [31:0]               o_remaining_ch1
);
    import dsps_pkg::*;

    localparam int NUM_W = $clog2(TICKS_NUMERATOR + 1);

    typedef struct packed {
        logic [CNT_W-1:0] remaining;
        logic [IVL_W-1:0] reload;
        logic [IVL_W-1:0] count;
        logic [3:0]       phase;
        logic             dir;
        logic [3:0]       coils;
        logic             en;
    } t_chan;

    // One tick on one channel: count down, and step the phase on expiry.
    function automatic t_chan f_tick(input t_chan s, input logic [2:0] typ);
        t_chan      n;
        logic [3:0] last;
        logic [3:0] p;
        n    = s;
        last = (typ == TYPE_HALF) ? PHASE_LAST_HALF : PHASE_LAST_FULL;
        p    = (s.phase == PHASE_BEFORE) ? 4'd0 : s.phase + 4'd1;
        if (s.remaining != '0) begin
            n.count = s.count - IVL_W'(1);
            if (n.count == '0) begin
                n.count = s.reload;
                if (s.dir) begin
                    n.phase = (p > last) ? 4'd0 : p;
                end else begin
                    n.phase = (s.phase == 4'd0 || s.phase == PHASE_BEFORE) ?
                              last : s.phase - 4'd1;
                end
                n.coils     = f_pattern(typ, n.phase, s.coils);
                n.remaining = s.remaining - CNT_W'(1);
                if (n.remaining == '0) begin
                    n.coils = 4'd0;
                    n.en    = 1'b0;
                end
            end
        end
        return n;
    endfunction

    // Configuration registers.
    logic [2:0]        r_type      [2];
    logic [SREV_W-1:0] r_steps_rev [4];

    // Captured item operands.
    logic [1:0]         r_op_kind;
    logic               r_op_ch;
    logic [CNT_W-1:0]   r_op_count;
    logic [SPEED_W-1:0] r_op_speed;
    logic               r_op_cw;

    // Shared serial divider.
    logic [NUM_W-1:0]  r_div_q;
    logic [NUM_W-1:0]  n_div_q;
    logic [SREV_W-1:0] r_div_rem;
    logic [SREV_W-1:0] n_div_rem;
    logic [SREV_W-1:0] r_div_den;
    logic [SREV_W-1:0] n_div_den;
    logic [SREV_W:0]   div_sh;
    logic [SREV_W:0]   div_diff;
    logic              div_bit;

    // Channel state.
    t_chan r_chan [2];
    t_chan n_chan [2];

    logic [2:0]        in_type;
    logic [2:0]        sr_sel;
    logic [SREV_W-1:0] sr_raw;
    logic [SPEED_W-1:0] sp_eff;
    logic [IVL_W-1:0]  div_ivl;
    logic [2:0]        op_type;

    // The start item needs the divider when the channel has a stepper type.
    assign in_type         = r_type[i_channel];
    assign o_sts.needs_div = (i_kind == KIND_START) && f_is_stepper(in_type);

    // Steps per revolution for the addressed type; zero is taken as one.
    assign sr_sel = in_type - 3'd1;
    assign sr_raw = r_steps_rev[sr_sel[1:0]];
    assign sp_eff = (r_op_speed == '0) ? SPEED_W'(1) : r_op_speed;

    // One restoring step per cycle while a division step is commanded.
    assign div_sh   = {r_div_rem, r_div_q[NUM_W-1]};
    assign div_diff = div_sh - {1'b0, r_div_den};
    assign div_bit  = (div_sh >= {1'b0, r_div_den});

    always_comb begin
        n_div_q   = r_div_q;
        n_div_rem = r_div_rem;
        n_div_den = r_div_den;
        if (i_cmd.div_load1) begin
            n_div_q   = NUM_W'(TICKS_NUMERATOR);
            n_div_rem = '0;
            n_div_den = (sr_raw == '0) ? SREV_W'(1) : sr_raw;
        end else if (i_cmd.div_load2) begin
            n_div_rem = '0;
            n_div_den = SREV_W'(sp_eff);
        end else if (i_cmd.div_step) begin
            n_div_rem = div_bit ? div_diff[SREV_W-1:0] : div_sh[SREV_W-1:0];
            n_div_q   = {r_div_q[NUM_W-2:0], div_bit};
        end
    end

    // Interval from the quotient, clamped to at least one.
    assign div_ivl = (r_div_q == '0) ? IVL_W'(1) : IVL_W'(r_div_q);
    assign op_type = r_type[r_op_ch];

    // Apply the captured item to the channel state.
    always_comb begin
        n_chan[0] = r_chan[0];
        n_chan[1] = r_chan[1];
        if (i_cmd.exec) begin
            unique case (r_op_kind)
                KIND_TICK: begin
                    n_chan[0] = f_tick(r_chan[0], r_type[0]);
                    n_chan[1] = f_tick(r_chan[1], r_type[1]);
                end
                KIND_START: begin
                    if (f_is_stepper(op_type)) begin
                        n_chan[r_op_ch].reload = div_ivl;
                        n_chan[r_op_ch].count  = div_ivl;
                    end else begin
                        n_chan[r_op_ch].count = r_chan[r_op_ch].reload;
                    end
                    n_chan[r_op_ch].dir = r_op_cw;
                    if (r_op_cw) begin
                        n_chan[r_op_ch].phase = PHASE_BEFORE;
                    end else begin
                        n_chan[r_op_ch].phase = (op_type == TYPE_HALF) ?
                                                PHASE_END_HALF : PHASE_END_FULL;
                    end
                    n_chan[r_op_ch].en        = 1'b1;
                    n_chan[r_op_ch].remaining = r_op_count;
                end
                KIND_STOP: begin
                    n_chan[r_op_ch].remaining = '0;
                end
                default: begin
                    n_chan[0] = r_chan[0];
                end
            endcase
        end
    end

    // Configuration and channel state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type[0]      <= TYPE_WAVE;
            r_type[1]      <= TYPE_WAVE;
            r_steps_rev[0] <= 16'd2048;
            r_steps_rev[1] <= 16'd2048;
            r_steps_rev[2] <= 16'd4096;
            r_steps_rev[3] <= 16'd200;
            r_chan[0]      <= '0;
            r_chan[1]      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TYPE_CH0:   r_type[0]      <= i_cfg_data[2:0];
                    CFG_TYPE_CH1:   r_type[1]      <= i_cfg_data[2:0];
                    CFG_STEPS_REV1: r_steps_rev[0] <= i_cfg_data;
                    CFG_STEPS_REV2: r_steps_rev[1] <= i_cfg_data;
                    CFG_STEPS_REV3: r_steps_rev[2] <= i_cfg_data;
                    CFG_STEPS_REV4: r_steps_rev[3] <= i_cfg_data;
                    default:        r_type[0]      <= r_type[0];
                endcase
            end
            r_chan[0] <= n_chan[0];
            r_chan[1] <= n_chan[1];
        end
    end

    // Operand capture, divider and result beat registers.
    always_ff @(posedge i_clk) begin
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
        r_div_den <= n_div_den;
        if (i_cmd.capture) begin
            r_op_kind  <= i_kind;
            r_op_ch    <= i_channel;
            r_op_count <= i_step_count;
            r_op_speed <= i_speed;
            r_op_cw    <= i_clockwise;
        end
        if (i_cmd.publish) begin
            o_coils_ch0     <= r_chan[0].coils;
            o_enable_ch0    <= r_chan[0].en;
            o_coils_ch1     <= r_chan[1].coils;
            o_enable_ch1    <= r_chan[1].en;
            o_remaining_ch0 <= r_chan[0].remaining;
            o_remaining_ch1 <= r_chan[1].remaining;
        end
    end

    // After the tick that finishes channel 0's last step, channel 0 drives no
    // coil and its enable is low.
    property p_done_coils_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op_kind == KIND_TICK && r_chan[0].remaining == CNT_W'(1)
         && r_chan[0].count == IVL_W'(1))
        |=> (r_chan[0].coils == 4'd0 && !r_chan[0].en);
    endproperty
    a_done_coils_clear: assert property (p_done_coils_clear)
        else $error("channel 0 finished but coils or enable still set");

    // The divider is never loaded and stepped in the same cycle.
    a_div_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.div_step && (i_cmd.div_load1 || i_cmd.div_load2)))
        else $error("divider load and step together");

    // A divisor loaded into the divider is never zero.
    a_div_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_load1 || i_cmd.div_load2) |=> (r_div_den != '0))
        else $error("divider loaded with a zero divisor");

endmodule

`default_nettype wire

FILE: sv/dsps_ctrl.sv
`default_nettype none

module dsps_ctrl #(
    parameter int unsigned TICKS_NUMERATOR = 600000
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire dsps_pkg::t_sts i_sts,
    output dsps_pkg::t_cmd      o_cmd
);
    import dsps_pkg::*;

    localparam int NUM_W  = $clog2(TICKS_NUMERATOR + 1);
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_LOAD2,
        ST_DIV2,
        ST_EXEC,
        ST_PUB
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              n_out_valid;
    logic              accept;
    logic              out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture   = accept;
        o_cmd.div_load1 = accept && i_sts.needs_div;
        o_cmd.div_load2 = (r_state == ST_LOAD2);
        o_cmd.div_step  = (r_state == ST_DIV1) || (r_state == ST_DIV2);
        o_cmd.exec      = (r_state == ST_EXEC);
        o_cmd.publish   = (r_state == ST_PUB) && out_free;
    end

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_sts.needs_div ? ST_DIV1 : ST_EXEC;
                    n_step  = STEP_W'(NUM_W - 1);
                end
            end
            ST_DIV1: begin
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = ST_LOAD2;
                end
            end
            ST_LOAD2: begin
                n_state = ST_DIV2;
                n_step  = STEP_W'(NUM_W - 1);
            end
            ST_DIV2: begin
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_PUB;
            ST_PUB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result beat valid: set on publish, cleared once taken.
    always_comb begin
        n_out_valid = o_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            o_out_valid <= n_out_valid;
        end
    end

    // A result beat appears only out of the publish state.
    a_valid_from_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_PUB))
        else $error("result beat raised outside publish");

    // Publishing never overwrites a beat that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!o_out_valid || !i_out_stall))
        else $error("result beat overwritten while stalled");

    // The second division starts only after the first has run out.
    a_load2_after_div1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD2) |-> ($past(r_state) == ST_DIV1 && $past(r_step) == '0))
        else $error("second division loaded early");

    // An accepted beat always moves the controller out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted beat left controller idle");

endmodule

`default_nettype wire

FILE: sv/dual_stepper_phase_sequencer.sv
`default_nettype none

// Two-channel stepper phase sequencer. Each input beat (tick, start or stop)
// produces exactly one result beat carrying both channels' coil drive, enable
// and remaining step count after the beat. A tick, a stop, or a start on a
// channel whose type is not a stepper passes through the execute and publish
// states to the result beat. A start on a stepper type computes its tick
// interval as TICKS_NUMERATOR / steps-per-revolution / speed with one shared
// restoring divider that yields one quotient bit per cycle, one bit for each
// bit of TICKS_NUMERATOR in each of the two divisions.
// Only one beat is in work at a time; the result sits in an output register,
// so the next input beat is taken while a result still waits to be read.
// Configuration writes are taken at any time but are meant for an idle block.
module dual_stepper_phase_sequencer #(
    parameter int unsigned TICKS_NUMERATOR = 600000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_channel,
    input  wire logic [31:0] i_step_count,
    input  wire logic [7:0]  i_speed,
    input  wire logic        i_clockwise,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_coils_ch0,
    output logic             o_enable_ch0,
    output logic [3:0]       o_coils_ch1,
    output logic             o_enable_ch1,
    output logic [31:0]      o_remaining_ch0,
    output logic [31:0]      o_remaining_ch1
);
    import dsps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing of item work and result beats.
    dsps_ctrl #(
        .TICKS_NUMERATOR (TICKS_NUMERATOR)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Channel state, configuration, divider and result registers.
    dsps_datapath #(
        .TICKS_NUMERATOR (TICKS_NUMERATOR)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_channel       (i_channel),
        .i_step_count    (i_step_count),
        .i_speed         (i_speed),
        .i_clockwise     (i_clockwise),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_coils_ch0     (o_coils_ch0),
        .o_enable_ch0    (o_enable_ch0),
        .o_coils_ch1     (o_coils_ch1),
        .o_enable_ch1    (o_enable_ch1),
        .o_remaining_ch0 (o_remaining_ch0),
        .o_remaining_ch1 (o_remaining_ch1)
    );

endmodule

`default_nettype wire
